### rtl/plst_pkg.sv
// Package for the positional list engine: request, status and state codes,
// and the control word broadcast to the row of storage cells. No dependencies.
package plst_pkg;

   localparam int VAL_W  = 32;
   localparam int TYPE_W = 3;
   localparam int POS_W  = 8;
   localparam int STAT_W = 2;
   localparam int EC_W   = 5;
   localparam int IDX_W  = 6;

   typedef enum logic [TYPE_W-1:0] {
      REQ_INS_FRONT = 3'd0,
      REQ_INS_BACK  = 3'd1,
      REQ_DEL_FRONT = 3'd2,
      REQ_DEL_BACK  = 3'd3,
      REQ_INS_AT    = 3'd4,
      REQ_DEL_AT    = 3'd5,
      REQ_READ_ALL  = 3'd6
   } req_code_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_BADPOS = 2'd2,
      STAT_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_op_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_READ = 1'b1
   } fsm_type;

   typedef struct packed {
      cell_op_type        op;
      logic [IDX_W-1:0]   idx;
      logic [IDX_W-1:0]   tail;
   } cell_ctrl_type;

endpackage

### rtl/plst_cell.sv
// One storage cell of the list row: holds one element and loads from its
// left or right neighbor, the insert value or the head. Depends on plst_pkg.
module plst_cell (
   input  logic                           clock,
   input  plst_pkg::cell_ctrl_type        ctrl,
   input  logic [plst_pkg::IDX_W-1:0]     cell_index,
   input  logic [plst_pkg::VAL_W-1:0]     ins_value,
   input  logic [plst_pkg::VAL_W-1:0]     head_value,
   input  logic [plst_pkg::VAL_W-1:0]     left_value,
   input  logic [plst_pkg::VAL_W-1:0]     right_value,
   output logic [plst_pkg::VAL_W-1:0]     value
);
   import plst_pkg::*;

   logic [VAL_W-1:0] value_ff;
   logic [VAL_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (cell_index == ctrl.idx) begin
               value_in = ins_value;
            end else if (cell_index > ctrl.idx) begin
               value_in = left_value;
            end
         end
         CELL_REMOVE: begin
            if (cell_index >= ctrl.idx) begin
               value_in = right_value;
            end
         end
         CELL_ROTATE: begin
            if (cell_index == ctrl.tail) begin
               value_in = head_value;
            end else if (cell_index < ctrl.tail) begin
               value_in = right_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

### rtl/plst_chain.sv
// Row of list cells wired to their neighbors; slot 0 is the head.
// Depends on plst_pkg and plst_cell.
module plst_chain #(
   parameter int CAPACITY = 16
) (
   input  logic                           clock,
   input  plst_pkg::cell_ctrl_type        ctrl,
   input  logic [plst_pkg::VAL_W-1:0]     ins_value,
   output logic [plst_pkg::VAL_W-1:0]     head_value
);
   import plst_pkg::*;

   logic [VAL_W-1:0] val_w [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VAL_W-1:0] left_w;
      logic [VAL_W-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = ins_value;
      end else begin : g_mid_l
         assign left_w = val_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_w = val_w[i];
      end else begin : g_mid_r
         assign right_w = val_w[i+1];
      end

      plst_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .cell_index  (IDX_W'(i)),
         .ins_value   (ins_value),
         .head_value  (val_w[0]),
         .left_value  (left_w),
         .right_value (right_w),
         .value       (val_w[i])
      );
   end

   assign head_value = val_w[0];

endmodule

### rtl/positional_list_engine_core.sv
// Top level of the positional list engine: request decode, length tracking,
// read-out sequencer and result register. Depends on plst_pkg and plst_chain.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit values in a row of
// cells, head in cell 0. Insert and delete requests shift the cells and give
// one result transaction each; with the result taken every cycle, one such
// request is accepted per clock. A read-all of L elements gives L results,
// one per cycle while the result is taken, as the row rotates its first L
// cells past the head; no request is accepted until the last of them is
// registered. Reading an empty list gives a single result with status empty.
// Rejected requests leave the list unchanged. element_count is the list
// length after the request, taken modulo 32.
module positional_list_engine_core #(
   parameter int CAPACITY = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [plst_pkg::TYPE_W-1:0]         req_type,
   input  logic signed [plst_pkg::VAL_W-1:0]   req_value,
   input  logic [plst_pkg::POS_W-1:0]          req_position,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [plst_pkg::STAT_W-1:0]         rsp_status,
   output logic [plst_pkg::EC_W-1:0]           rsp_element_count,
   output logic signed [plst_pkg::VAL_W-1:0]   rsp_read_value,
   output logic                                rsp_last_result
);
   import plst_pkg::*;

   localparam int IW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   fsm_type           state_ff, state_in;
   logic [CW-1:0]     len_ff, len_in;
   logic [IW-1:0]     cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic [EC_W-1:0]   count_ff, count_in;
   logic [VAL_W-1:0]  rdval_ff, rdval_in;
   logic              last_ff, last_in;

   cell_ctrl_type     ctrl;
   logic [VAL_W-1:0]  head_w;
   logic              accept;
   logic              out_free;
   logic              load;
   logic              full;
   logic              empty;
   logic [CMPW-1:0]   pos_ext;
   logic [CMPW-1:0]   len_ext;
   logic [IW-1:0]     tail_w;

   plst_chain #(
      .CAPACITY (CAPACITY)
   ) u_chain (
      .clock      (clock),
      .ctrl       (ctrl),
      .ins_value  (req_value),
      .head_value (head_w)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff == FSM_READ) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign full      = (len_ff == CW'(CAPACITY));
   assign empty     = (len_ff == '0);
   assign pos_ext   = CMPW'(req_position);
   assign len_ext   = CMPW'(len_ff);
   assign tail_w    = IW'(len_ff - CW'(1));

   always_comb begin
      state_in  = state_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      load      = 1'b0;
      status_in = status_ff;
      count_in  = count_ff;
      rdval_in  = rdval_ff;
      last_in   = last_ff;
      ctrl.op   = CELL_HOLD;
      ctrl.idx  = '0;
      ctrl.tail = IDX_W'(tail_w);

      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               load      = 1'b1;
               status_in = STAT_OK;
               rdval_in  = '0;
               last_in   = 1'b1;
               case (req_type)
                  REQ_INS_FRONT, REQ_INS_BACK: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        ctrl.op  = CELL_INSERT;
                        ctrl.idx = (req_type == REQ_INS_FRONT) ? '0 : IDX_W'(len_ff);
                        len_in   = len_ff + CW'(1);
                     end
                  end
                  REQ_DEL_FRONT, REQ_DEL_BACK: begin
                     if (empty) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        ctrl.op  = CELL_REMOVE;
                        ctrl.idx = (req_type == REQ_DEL_FRONT) ? '0 : IDX_W'(tail_w);
                        len_in   = len_ff - CW'(1);
                     end
                  end
                  REQ_INS_AT: begin
                     if ((req_position == '0) || (pos_ext > len_ext + CMPW'(1))) begin
                        status_in = STAT_BADPOS;
                     end else if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        ctrl.op  = CELL_INSERT;
                        ctrl.idx = IDX_W'(req_position - POS_W'(1));
                        len_in   = len_ff + CW'(1);
                     end
                  end
                  REQ_DEL_AT: begin
                     if ((req_position == '0) || (pos_ext > len_ext)) begin
                        status_in = STAT_BADPOS;
                     end else begin
                        ctrl.op  = CELL_REMOVE;
                        ctrl.idx = IDX_W'(req_position - POS_W'(1));
                        len_in   = len_ff - CW'(1);
                     end
                  end
                  REQ_READ_ALL: begin
                     if (empty) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        load     = 1'b0;
                        cnt_in   = '0;
                        state_in = FSM_READ;
                     end
                  end
                  default: status_in = STAT_OK;
               endcase
               count_in = EC_W'(len_in);
            end
         end
         FSM_READ: begin
            if (out_free) begin
               load      = 1'b1;
               status_in = STAT_OK;
               count_in  = EC_W'(len_ff);
               rdval_in  = head_w;
               last_in   = (cnt_ff == tail_w);
               ctrl.op   = CELL_ROTATE;
               cnt_in    = cnt_ff + IW'(1);
               if (cnt_ff == tail_w) begin
                  state_in = FSM_IDLE;
               end
            end
         end
         default: state_in = FSM_IDLE;
      endcase

      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         len_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      count_ff  <= count_in;
      rdval_ff  <= rdval_in;
      last_ff   <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_element_count = count_ff;
   assign rsp_read_value    = rdval_ff;
   assign rsp_last_result   = last_ff;

endmodule
